FILE: hw/rtl/mpc_pkg.sv
package mpc_pkg;

  localparam int MAX_SIZE_DEF      = 16;
  localparam int ELEMENT_WIDTH_DEF = 32;
  localparam int IN_DATA_W         = 32;
  localparam int SIZE_REG_W        = 5;
  localparam int SUM_W             = 40;
  localparam int CODE_W            = 2;
  localparam int APB_DATA_W        = 32;
  localparam int APB_ADDR_W        = 3;
  localparam int OUT_DATA_W        = 88;
  localparam logic [SIZE_REG_W-1:0] SIZE_RESET = SIZE_REG_W'(16);

  localparam logic [APB_ADDR_W-3:0] REG_MATRIX_SIZE = '0;

  typedef enum logic [CODE_W-1:0] {
    CLASS_SYMMETRIC = 2'd0,
    CLASS_LOWER     = 2'd1,
    CLASS_DIAGONAL  = 2'd2,
    CLASS_NONE      = 2'd3
  } class_code_t;

  typedef struct packed {
    logic [SUM_W-1:0] anti_diagonal_sum;
    logic [SUM_W-1:0] trace_sum;
    class_code_t      class_code;
    logic             is_diagonal;
    logic             is_lower_triangular;
    logic             is_symmetric;
  } result_t;

endpackage

FILE: hw/rtl/matrix_property_checker_unit.sv
// flow: an accepted word is registered into the compare stage and from there folded into the flags and
//   sums; the result word of a matrix is loaded into the output register as its last element leaves that stage
// throughput: one element per cycle while s_tready is high, using the store's separate read and write ports; the input
//   stalls only while a result waits unread and the next matrix's last element is also done
// reset: clears indices, flags, sums and the pipeline; matrix_size returns to 16;
//   the element store is not cleared and needs no clearing pass
module matrix_property_checker_unit
  import mpc_pkg::*;
#(
  parameter int MAX_SIZE      = MAX_SIZE_DEF,
  parameter int ELEMENT_WIDTH = ELEMENT_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,   // element_value
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // is_symmetric, is_lower_triangular, is_diagonal, class_code, trace_sum, anti_diagonal_sum
  output logic [OUT_DATA_W-1:0] m_tdata,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int DEPTH = MAX_SIZE * MAX_SIZE;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int IW    = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
  localparam int SZ_W  = $clog2(MAX_SIZE + 1);
  localparam int EW    = ELEMENT_WIDTH;

  logic [SIZE_REG_W-1:0] matrix_size;
  logic [SZ_W-1:0]       n_eff;
  logic [SZ_W-1:0]       n_m1;
  logic                  cfg_wr;

  logic [IW-1:0] row;
  logic [IW-1:0] col;
  logic [IW-1:0] row_next;
  logic [IW-1:0] col_next;

  logic          in_fire;
  logic [EW-1:0] in_v;
  logic          pos_upper;
  logic          pos_lower;
  logic          pos_diag;
  logic          pos_anti;
  logic          pos_last;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] rd_addr;

  logic          s1_valid;
  logic [EW-1:0] s1_v;
  logic          s1_upper;
  logic          s1_lower;
  logic          s1_diag;
  logic          s1_anti;
  logic          s1_last;
  logic          s1_stall;
  logic          s1_fire;
  logic [EW-1:0] rd_data;

  logic             sym_flag;
  logic             low_flag;
  logic             dia_flag;
  logic [SUM_W-1:0] trace_acc;
  logic [SUM_W-1:0] anti_acc;
  logic             sym_next;
  logic             low_next;
  logic             dia_next;
  logic [SUM_W-1:0] trace_next;
  logic [SUM_W-1:0] anti_next;
  logic [SUM_W-1:0] s1_ext;
  logic             s1_nonzero;

  result_t     res;
  result_t     res_next;
  class_code_t code_next;

  // config port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready
                  && (paddr[APB_ADDR_W-1:2] == REG_MATRIX_SIZE);
  assign prdata = {{(APB_DATA_W-SIZE_REG_W){1'b0}}, matrix_size};

  always_ff @(posedge clk) begin
    if (rst) begin
      matrix_size <= SIZE_RESET;
    end else if (cfg_wr) begin
      matrix_size <= pwdata[SIZE_REG_W-1:0];
    end
  end

  always_comb begin
    priority if (matrix_size == '0) begin
      n_eff = SZ_W'(1);
    end else if (int'(matrix_size) > MAX_SIZE) begin
      n_eff = SZ_W'(MAX_SIZE);
    end else begin
      n_eff = SZ_W'(matrix_size);
    end
    n_m1 = n_eff - SZ_W'(1);
  end

  // position decode
  assign in_fire   = s_tvalid && s_tready;
  assign in_v      = s_tdata[EW-1:0];
  assign pos_upper = row < col;
  assign pos_lower = row > col;
  assign pos_diag  = row == col;
  assign pos_anti  = ((SZ_W+1)'(row) + (SZ_W+1)'(col)) == (SZ_W+1)'(n_m1);
  assign pos_last  = (SZ_W'(row) == n_m1) && (SZ_W'(col) == n_m1);
  assign wr_addr   = AW'(row) * AW'(MAX_SIZE) + AW'(col);
  assign rd_addr   = AW'(col) * AW'(MAX_SIZE) + AW'(row);

  always_comb begin
    row_next = row;
    col_next = col;
    priority if (pos_last) begin
      row_next = '0;
      col_next = '0;
    end else if (SZ_W'(col) == n_m1) begin
      row_next = row + IW'(1);
      col_next = '0;
    end else begin
      col_next = col + IW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_wr) begin
      row <= '0;
      col <= '0;
    end else if (in_fire) begin
      row <= row_next;
      col <= col_next;
    end
  end

  // upper elements are written on accept; the mirror of a lower element is always written before it is read
  mpc_elem_store #(
    .DEPTH (DEPTH),
    .WIDTH (EW),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .wr_en   (in_fire && pos_upper),
    .wr_addr (wr_addr),
    .wr_data (in_v),
    .rd_en   (in_fire),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // compare and accumulate stage
  assign s1_stall = s1_valid && s1_last && m_tvalid && !m_tready;
  assign s1_fire  = s1_valid && !s1_stall;
  assign s_tready = !s1_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!s1_stall) begin
      s1_valid <= in_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_v     <= in_v;
      s1_upper <= pos_upper;
      s1_lower <= pos_lower;
      s1_diag  <= pos_diag;
      s1_anti  <= pos_anti;
      s1_last  <= pos_last;
    end
  end

  assign s1_ext     = {{(SUM_W-EW){s1_v[EW-1]}}, s1_v};
  assign s1_nonzero = s1_v != '0;

  always_comb begin
    sym_next   = sym_flag && !(s1_lower && (rd_data != s1_v));
    low_next   = low_flag && !(s1_upper && s1_nonzero);
    dia_next   = dia_flag && !((s1_upper || s1_lower) && s1_nonzero);
    trace_next = s1_diag ? trace_acc + s1_ext : trace_acc;
    anti_next  = s1_anti ? anti_acc + s1_ext : anti_acc;
    priority if (sym_next) begin
      code_next = CLASS_SYMMETRIC;
    end else if (low_next) begin
      code_next = CLASS_LOWER;
    end else if (dia_next) begin
      code_next = CLASS_DIAGONAL;
    end else begin
      code_next = CLASS_NONE;
    end
    res_next.is_symmetric        = sym_next;
    res_next.is_lower_triangular = low_next;
    res_next.is_diagonal         = dia_next;
    res_next.class_code          = code_next;
    res_next.trace_sum           = trace_next;
    res_next.anti_diagonal_sum   = anti_next;
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_wr || (s1_fire && s1_last)) begin
      sym_flag  <= 1'b1;
      low_flag  <= 1'b1;
      dia_flag  <= 1'b1;
      trace_acc <= '0;
      anti_acc  <= '0;
    end else if (s1_fire) begin
      sym_flag  <= sym_next;
      low_flag  <= low_next;
      dia_flag  <= dia_next;
      trace_acc <= trace_next;
      anti_acc  <= anti_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s1_fire && s1_last) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_last) begin
      res <= res_next;
    end
  end

  assign m_tdata = {{(OUT_DATA_W-$bits(result_t)){1'b0}}, res};

  // checks
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (m_tvalid && !m_tready && s1_valid && s1_last))
    else $error("input stalled without a waiting result");

  a_last_gives_result: assert property (@(posedge clk) disable iff (rst)
    (s1_fire && s1_last) |=> m_tvalid)
    else $error("finished matrix did not load the result register");

  a_index_in_range: assert property (@(posedge clk) disable iff (rst)
    (SZ_W'(row) < n_eff) && (SZ_W'(col) < n_eff))
    else $error("element position outside the matrix");

  a_upper_lower_excl: assert property (@(posedge clk) disable iff (rst)
    s1_valid |-> !(s1_upper && s1_lower) && !((s1_upper || s1_lower) && s1_diag))
    else $error("element classified into more than one region");

endmodule

FILE: hw/rtl/mpc_elem_store.sv
module mpc_elem_store
  import mpc_pkg::*;
#(
  parameter int DEPTH = MAX_SIZE_DEF * MAX_SIZE_DEF,
  parameter int WIDTH = ELEMENT_WIDTH_DEF,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
